// ===== rtl/pth_pkg.sv =====
// Shared types and constants for the sensor compensation pipeline.
// Used by pth_sensor_compensation_unit; depends on nothing else.
`default_nettype none
package pth_pkg;

   localparam int unsigned NumStages = 51;
   localparam int unsigned DivFirst  = 15;
   localparam int unsigned DivLast   = 46;

   localparam logic [2:0] REG_TEMP   = 3'd0;
   localparam logic [2:0] REG_PRESS1 = 3'd1;
   localparam logic [2:0] REG_PRESS2 = 3'd2;
   localparam logic [2:0] REG_PRESS9 = 3'd3;
   localparam logic [2:0] REG_HUM    = 3'd4;

   localparam logic [31:0] TempOffset   = 32'd64000;
   localparam logic [31:0] PressBase    = 32'd1048576;
   localparam logic [31:0] PressScale   = 32'd3125;
   localparam logic [31:0] HumOffset    = 32'd76800;
   localparam logic [31:0] HumLimit     = 32'd419430400;
   localparam logic [31:0] HumBias      = 32'd2097152;
   localparam logic [31:0] HumRound     = 32'd16384;
   localparam logic [31:0] HumHalf      = 32'd32768;
   localparam logic [31:0] HumRoundLow  = 32'd8192;
   localparam logic [16:0] HumMaxOut    = 17'd102400;

   typedef struct packed {
      logic [19:0] at;
      logic [19:0] ap;
      logic [15:0] ah;
      logic [31:0] x1;
      logic [31:0] d;
      logic [31:0] m1;
      logic [31:0] dd;
      logic [31:0] m2;
      logic [31:0] tf;
      logic [31:0] temp;
      logic [31:0] a;
      logic [31:0] hv;
      logic [31:0] qq;
      logic [31:0] ma5;
      logic [31:0] mp2;
      logic [31:0] mh5;
      logic [31:0] mh6;
      logic [31:0] mh3;
      logic [31:0] v2;
      logic [31:0] mp3;
      logic [31:0] mp8;
      logic [31:0] left;
      logic [31:0] i6;
      logic [31:0] i3;
      logic [31:0] v1p;
      logic [31:0] inm;
      logic [31:0] mv1;
      logic [31:0] pn;
      logic [31:0] inner;
      logic [31:0] dv;
      logic [31:0] pm;
      logic [31:0] rm;
      logic [31:0] right;
      logic [31:0] sq;
      logic [31:0] hm;
      logic        zf;
      logic        big;
      logic [16:0] hum;
      logic [32:0] rem;
      logic [31:0] num;
      logic [31:0] p;
   } pipe_type;

   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
      return $unsigned($signed(v) >>> s);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/pth_sensor_compensation_unit.sv =====
// Temperature, pressure and humidity compensation, fully pipelined.
// Uses pth_pkg for the stage record, constants and the arithmetic shift.
//
// Usage: a request on req_* carries one raw temperature, pressure and humidity
// triple. Calibration is written through csr_* while the block is idle.
// One result leaves on rsp_* for every request, in order.
// The pipeline has 51 register stages, and rsp_tvalid is the valid bit of the last.
// One request can be accepted every cycle while req_tready is high; most of
// the stages are the 32 of the pressure divider, one quotient bit per stage.
// Empty stages close up, so requests keep entering while a result waits.
// When the receiver holds rsp_tready low the full pipeline stops and nothing
// is lost or repeated; req_tready falls once every stage is occupied.
// A synchronous reset empties the pipeline and clears all calibration to 0.
// A zero pressure divisor gives pressure 0 with the flag in rsp_tuser set.
`default_nettype none
module pth_sensor_compensation_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // temperature_centi [31:0], pressure_pa [63:32], humidity_q7_10 [80:64]
   output logic [87:0]      rsp_tdata,
   // pressure_div_zero [0]
   output logic             rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int unsigned NS = pth_pkg::NumStages;

   logic [47:0] temp_cal_ff;
   logic [63:0] press1_ff;
   logic [63:0] press2_ff;
   logic [15:0] press9_ff;
   logic [63:0] hum_cal_ff;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;

   pth_pkg::pipe_type st_ff [NS];
   pth_pkg::pipe_type st_in [NS];
   logic [NS-1:0]     vld_ff;
   logic [NS-1:0]     ld;

   always_comb begin
      t1 = {16'd0, temp_cal_ff[15:0]};
      t2 = {{16{temp_cal_ff[31]}}, temp_cal_ff[31:16]};
      t3 = {{16{temp_cal_ff[47]}}, temp_cal_ff[47:32]};
      p1 = {16'd0, press1_ff[15:0]};
      p2 = {{16{press1_ff[31]}}, press1_ff[31:16]};
      p3 = {{16{press1_ff[47]}}, press1_ff[47:32]};
      p4 = {{16{press1_ff[63]}}, press1_ff[63:48]};
      p5 = {{16{press2_ff[15]}}, press2_ff[15:0]};
      p6 = {{16{press2_ff[31]}}, press2_ff[31:16]};
      p7 = {{16{press2_ff[47]}}, press2_ff[47:32]};
      p8 = {{16{press2_ff[63]}}, press2_ff[63:48]};
      p9 = {{16{press9_ff[15]}}, press9_ff};
      h1 = {24'd0, hum_cal_ff[7:0]};
      h2 = {{16{hum_cal_ff[23]}}, hum_cal_ff[23:8]};
      h3 = {24'd0, hum_cal_ff[31:24]};
      h4 = {{20{hum_cal_ff[43]}}, hum_cal_ff[43:32]};
      h5 = {{20{hum_cal_ff[55]}}, hum_cal_ff[55:44]};
      h6 = {{24{hum_cal_ff[63]}}, hum_cal_ff[63:56]};
   end

   function automatic pth_pkg::pipe_type step(input int unsigned k,
                                              input pth_pkg::pipe_type s);
      pth_pkg::pipe_type r;
      logic [31:0] q;
      logic [31:0] t;
      logic [32:0] rr;
      r = s;
      q = 32'd0;
      t = 32'd0;
      rr = 33'd0;
      case (k) inside
         0: begin
            r.x1 = {12'd0, s.at >> 3} - (t1 << 1);
            r.d  = {12'd0, s.at >> 4} - t1;
         end
         1: begin
            r.m1 = s.x1 * t2;
            r.dd = s.d * s.d;
         end
         2: begin
            r.x1 = pth_pkg::asr(s.m1, 11);
            r.m2 = pth_pkg::asr(s.dd, 12) * t3;
         end
         3: r.tf = s.x1 + pth_pkg::asr(s.m2, 14);
         4: begin
            r.temp = pth_pkg::asr((s.tf << 2) + s.tf + 32'd128, 8);
            r.a    = pth_pkg::asr(s.tf, 1) - pth_pkg::TempOffset;
            r.hv   = s.tf - pth_pkg::HumOffset;
         end
         5: begin
            q     = pth_pkg::asr(s.a, 2);
            r.qq  = q * q;
            r.ma5 = s.a * p5;
            r.mp2 = p2 * s.a;
            r.mh5 = h5 * s.hv;
            r.mh6 = s.hv * h6;
            r.mh3 = s.hv * h3;
         end
         6: begin
            r.v2   = pth_pkg::asr(s.qq, 11) * p6;
            r.mp3  = p3 * pth_pkg::asr(s.qq, 13);
            r.left = pth_pkg::asr(({16'd0, s.ah} << 14) - (h4 << 20) - s.mh5
                                  + pth_pkg::HumRound, 15);
            r.i6   = pth_pkg::asr(s.mh6, 10);
            r.i3   = pth_pkg::asr(s.mh3, 11) + pth_pkg::HumHalf;
         end
         7: begin
            r.v2  = pth_pkg::asr(s.v2 + (s.ma5 << 1), 2) + (p4 << 16);
            r.v1p = pth_pkg::asr(pth_pkg::asr(s.mp3, 3) + pth_pkg::asr(s.mp2, 1), 18);
            r.inm = s.i6 * s.i3;
         end
         8: begin
            r.mv1   = (pth_pkg::HumHalf + s.v1p) * p1;
            r.pn    = (pth_pkg::PressBase - {12'd0, s.ap}) - pth_pkg::asr(s.v2, 12);
            r.inner = pth_pkg::asr(s.inm, 10);
         end
         9: begin
            r.dv = pth_pkg::asr(s.mv1, 15);
            r.pm = s.pn * pth_pkg::PressScale;
            r.rm = (s.inner + pth_pkg::HumBias) * h2;
         end
         10: begin
            r.right = pth_pkg::asr(s.rm + pth_pkg::HumRoundLow, 14);
            r.zf    = (s.dv == 32'd0);
            r.big   = s.pm[31];
            r.num   = s.pm[31] ? s.pm : (s.pm << 1);
            r.rem   = 33'd0;
         end
         11: r.hv = s.left * s.right;
         12: begin
            q    = pth_pkg::asr(s.hv, 15);
            r.sq = q * q;
         end
         13: r.hm = pth_pkg::asr(s.sq, 7) * h1;
         14: begin
            t = s.hv - pth_pkg::asr(s.hm, 4);
            if (t[31]) begin
               t = 32'd0;
            end
            if (t > pth_pkg::HumLimit) begin
               t = pth_pkg::HumLimit;
            end
            r.hum = t[28:12];
         end
         [pth_pkg::DivFirst:pth_pkg::DivLast]: begin
            rr = {s.rem[31:0], s.num[31]};
            if (rr >= {1'b0, s.dv}) begin
               r.rem = rr - {1'b0, s.dv};
               r.num = {s.num[30:0], 1'b1};
            end else begin
               r.rem = rr;
               r.num = {s.num[30:0], 1'b0};
            end
         end
         47: begin
            t     = s.big ? (s.num << 1) : s.num;
            q     = t >> 3;
            r.p   = t;
            r.qq  = q * q;
            r.mp8 = (t >> 2) * p8;
         end
         48: begin
            r.mp3 = p9 * (s.qq >> 13);
            r.v2  = pth_pkg::asr(s.mp8, 13);
         end
         default: begin
            t   = s.p + pth_pkg::asr(pth_pkg::asr(s.mp3, 12) + s.v2 + p7, 4);
            r.p = s.zf ? 32'd0 : t;
         end
      endcase
      return r;
   endfunction

   always_comb begin
      st_in[0]    = st_ff[0];
      st_in[0].at = req_tdata[19:0];
      st_in[0].ap = req_tdata[39:20];
      st_in[0].ah = req_tdata[55:40];
      for (int unsigned k = 1; k < NS; k++) begin
         st_in[k] = step(k - 1, st_ff[k-1]);
      end
   end

   always_comb begin
      ld[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         temp_cal_ff <= '0;
         press1_ff   <= '0;
         press2_ff   <= '0;
         press9_ff   <= '0;
         hum_cal_ff  <= '0;
      end else begin
         if (ld[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int unsigned k = 1; k < NS; k++) begin
            if (ld[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               pth_pkg::REG_TEMP:   temp_cal_ff <= csr_wdata[47:0];
               pth_pkg::REG_PRESS1: press1_ff   <= csr_wdata;
               pth_pkg::REG_PRESS2: press2_ff   <= csr_wdata;
               pth_pkg::REG_PRESS9: press9_ff   <= csr_wdata[15:0];
               pth_pkg::REG_HUM:    hum_cal_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned k = 0; k < NS; k++) begin
         if (ld[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign req_tready = ld[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {7'd0, st_ff[NS-1].hum, st_ff[NS-1].p, st_ff[NS-1].temp};
   assign rsp_tuser  = st_ff[NS-1].zf;

`ifndef SYNTHESIS
   a_zero_div_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:32] == 32'd0)
      else $error("Zero divisor result carries non-zero pressure.");
   a_humidity_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[80:64] <= pth_pkg::HumMaxOut)
      else $error("Humidity beyond its clamped range.");
   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("Pipeline not empty after reset.");
`endif

endmodule
`default_nettype wire

// ===== bench/pth_sensor_compensation_unit_tb.sv =====
// Testbench for pth_sensor_compensation_unit: random and directed readings are
// checked against a predictor of the 32-bit integer compensation arithmetic.
// Depends on pth_pkg for the register indexes and on the unit itself.
`timescale 1ns / 100ps
`default_nettype none
module pth_sensor_compensation_unit_tb;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic        divz;
      logic [16:0] hum;
   } reading_type;

   typedef struct {
      logic [19:0] at;
      logic [19:0] ap;
      logic [15:0] ah;
      bit          fixed;
      logic [31:0] temp;
      logic [31:0] press;
      logic        divz;
      logic [16:0] hum;
   } row_type;

   localparam int Latency = 60;
   localparam int IdleLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic [47:0] cal_temp;
   logic [63:0] cal_p1, cal_p2, cal_hum;
   logic [15:0] cal_p9;

   reading_type compensated_q[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          hold_rsp = 1'b0;
   bit          stim_done = 1'b0;

   pth_sensor_compensation_unit dut (.*);

   always #10 clock = ~clock;

   function automatic logic [31:0] sra(input logic [31:0] v, input int s);
      return $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] sxt(input logic [63:0] v, input int w);
      logic [31:0] x;
      x = v[31:0] & ((32'd1 << w) - 1);
      if (x[w-1]) x = x | ~((32'd1 << w) - 1);
      return x;
   endfunction

   function automatic reading_type compensate(input logic [19:0] at, input logic [19:0] ap,
                                             input logic [15:0] ah);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] v1, v2, d, tf, a, q, qq, p, hv, left, inner, right;
      reading_type r;
      t1 = {16'd0, cal_temp[15:0]};
      t2 = sxt(cal_temp >> 16, 16);
      t3 = sxt(cal_temp >> 32, 16);
      p1 = {16'd0, cal_p1[15:0]};
      p2 = sxt(cal_p1 >> 16, 16);
      p3 = sxt(cal_p1 >> 32, 16);
      p4 = sxt(cal_p1 >> 48, 16);
      p5 = sxt(cal_p2, 16);
      p6 = sxt(cal_p2 >> 16, 16);
      p7 = sxt(cal_p2 >> 32, 16);
      p8 = sxt(cal_p2 >> 48, 16);
      p9 = sxt({48'd0, cal_p9}, 16);
      h1 = {24'd0, cal_hum[7:0]};
      h2 = sxt(cal_hum >> 8, 16);
      h3 = {24'd0, cal_hum[31:24]};
      h4 = sxt(cal_hum >> 32, 12);
      h5 = sxt(cal_hum >> 44, 12);
      h6 = sxt(cal_hum >> 56, 8);
      v1 = sra((sra({12'd0, at}, 3) - (t1 << 1)) * t2, 11);
      d = sra({12'd0, at}, 4) - t1;
      v2 = sra(sra(d * d, 12) * t3, 14);
      tf = v1 + v2;
      r.temp = sra(tf * 32'd5 + 32'd128, 8);
      a = sra(tf, 1) - 32'd64000;
      q = sra(a, 2);
      qq = q * q;
      v2 = sra(qq, 11) * p6;
      v2 = v2 + ((a * p5) << 1);
      v2 = sra(v2, 2) + (p4 << 16);
      v1 = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * a, 1), 18);
      v1 = sra((32'd32768 + v1) * p1, 15);
      r.divz = (v1 == 0);
      if (r.divz) begin
         p = 0;
      end else begin
         p = ((32'd1048576 - {12'd0, ap}) - sra(v2, 12)) * 32'd3125;
         if (!p[31]) p = (p << 1) / v1;
         else p = (p / v1) * 32'd2;
         q = p >> 3;
         v1 = sra(p9 * ((q * q) >> 13), 12);
         v2 = sra((p >> 2) * p8, 13);
         p = p + sra(v1 + v2 + p7, 4);
      end
      r.press = p;
      hv = tf - 32'd76800;
      left = sra(({16'd0, ah} << 14) - (h4 << 20) - h5 * hv + 32'd16384, 15);
      inner = sra(sra(hv * h6, 10) * (sra(hv * h3, 11) + 32'd32768), 10);
      right = sra((inner + 32'd2097152) * h2 + 32'd8192, 14);
      hv = left * right;
      q = sra(hv, 15);
      hv = hv - sra(sra(q * q, 7) * h1, 4);
      if (hv[31]) hv = 0;
      if (hv > 32'd419430400) hv = 32'd419430400;
      r.hum = hv[28:12];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
   endtask

   task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         pth_pkg::REG_TEMP:   cal_temp = val[47:0];
         pth_pkg::REG_PRESS1: cal_p1 = val;
         pth_pkg::REG_PRESS2: cal_p2 = val;
         pth_pkg::REG_PRESS9: cal_p9 = val[15:0];
         pth_pkg::REG_HUM:    cal_hum = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_reading(input logic [19:0] at, input logic [19:0] ap,
                               input logic [15:0] ah);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {ah, ap, at};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      compensated_q.push_back(compensate(at, ap, ah));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain;
      while (compensated_q.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 19) == 0) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || rsp_tready;
   end

   always @(posedge clock) begin
      reading_type w, g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g.temp = rsp_tdata[31:0];
         g.press = rsp_tdata[63:32];
         g.hum = rsp_tdata[80:64];
         g.divz = rsp_tuser;
         if (compensated_q.size() == 0) begin
            report_mismatch("unexpected result", g.temp, 0);
         end else begin
            w = compensated_q.pop_front();
            if (g.temp !== w.temp) report_mismatch("temperature", g.temp, w.temp);
            if (g.press !== w.press) report_mismatch("pressure", g.press, w.press);
            if (g.divz !== w.divz) report_mismatch("divisor flag", g.divz, w.divz);
            if (g.hum !== w.hum) report_mismatch("humidity", g.hum, w.hum);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Long receiver hold-off while requests keep coming, to fill the pipeline.
   initial begin
      wait (stim_done == 1'b0 && !reset);
      repeat (400) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] plausible_cal(input int idx);
      case (idx)
         0: return {16'd0, $urandom_range(0, 1) ? 8'hff : 8'h00, 8'($urandom),
                    16'($urandom_range(25000, 28000)), 16'($urandom_range(27000, 29000))};
         1: return {16'($urandom_range(2000, 9000)), 16'hf000 | 16'($urandom_range(0, 4095)),
                    16'hd000 | 16'($urandom_range(0, 4095)), 16'($urandom_range(30000, 40000))};
         2: return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'hfff0 | 16'($urandom_range(0, 15)), 16'($urandom_range(0, 500))};
         3: return 64'($urandom_range(0, 65535));
         default: return {8'($urandom_range(0, 60)), 12'($urandom_range(0, 100)),
                          12'($urandom_range(200, 400)), 8'($urandom_range(0, 20)),
                          16'($urandom_range(300, 400)), 8'($urandom_range(50, 100))};
      endcase
   endfunction

   row_type rows[$];

   initial begin
      row_type r;
      int phase, k, i;
      cal_temp = '0; cal_p1 = '0; cal_p2 = '0; cal_p9 = '0; cal_hum = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // After reset every calibration word is zero: divisor zero, outputs fixed.
      rows.push_back('{20'd0, 20'd0, 16'd0, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0});
      rows.push_back('{20'hfffff, 20'hfffff, 16'hffff, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0});
      rows.push_back('{20'hfffff, 20'd0, 16'd0, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0});
      rows.push_back('{20'd0, 20'hfffff, 16'hffff, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0});
      foreach (rows[j]) begin
         r = rows[j];
         send_reading(r.at, r.ap, r.ah);
         if (r.fixed && compensate(r.at, r.ap, r.ah) !== {r.temp, r.press, r.divz, r.hum})
            report_mismatch("directed row", j, 0);
      end
      drain();

      // Typical, extreme and random calibration; readings at field limits and at random.
      for (phase = 0; phase < 8; phase++) begin
         for (i = 0; i < 5; i++) begin
            case (phase) inside
               0, 3, 5: write_cal(3'(i), plausible_cal(i));
               1: write_cal(3'(i), 64'hffff_ffff_ffff_ffff);
               2: write_cal(3'(i), (i == 4) ? 64'h7f7f_f7ff_7fff_ff7f
                                            : 64'h7fff_7fff_7fff_ffff);
               4: write_cal(3'(i), (i == 4) ? 64'h8080_0800_8000_0080
                                            : 64'h8000_8000_8000_0001);
               default: write_cal(3'(i), rand64());
            endcase
         end
         if (phase == 0) begin
            write_cal(3'd5, rand64());
            send_reading(20'h80000, 20'h60000, 16'h7000);
            send_reading(20'd0, 20'd0, 16'd0);
            send_reading(20'hfffff, 20'hfffff, 16'hffff);
            send_reading(20'h7ffff, 20'h80000, 16'h8000);
         end
         k = (phase == 0 || phase == 3 || phase == 5) ? 300 : 120;
         for (i = 0; i < k; i++) begin
            case ($urandom_range(0, 5))
               0: send_reading(20'($urandom), 20'($urandom), 16'($urandom));
               1: send_reading($urandom_range(0, 1) ? 20'hfffff : 20'd0,
                               $urandom_range(0, 1) ? 20'hfffff : 20'd0, 16'($urandom));
               default: send_reading(20'($urandom_range(400000, 600000)),
                                     20'($urandom_range(250000, 450000)),
                                     16'($urandom_range(20000, 40000)));
            endcase
         end
         drain();
      end
      stim_done = 1'b1;
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
